/* src/dcts_pkg.sv */
package dcts_pkg;

   localparam int MAX_TASKS_DEFAULT = 64;
   localparam int CNT_W  = 7;
   localparam int WAIT_W = 6;

   localparam logic [2:0] OP_SPAWN    = 3'd0;
   localparam logic [2:0] OP_DISPATCH = 3'd1;
   localparam logic [2:0] OP_COMPLETE = 3'd2;
   localparam logic [2:0] OP_CANCEL   = 3'd3;
   localparam logic [2:0] OP_RELEASE  = 3'd4;
   localparam logic [2:0] OP_QUERY    = 3'd5;

   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_DRAINED    = 3'd1;
   localparam logic [2:0] STS_FULL       = 3'd2;
   localparam logic [2:0] STS_EMPTY      = 3'd3;
   localparam logic [2:0] STS_RELEASED   = 3'd4;
   localparam logic [2:0] STS_BAD_COMPLT = 3'd5;

   localparam logic [1:0] TS_ADMITTED  = 2'd0;
   localparam logic [1:0] TS_SUCCEEDED = 2'd1;
   localparam logic [1:0] TS_FAILED    = 2'd2;
   localparam logic [1:0] TS_CANCELED  = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] dep_mask;
      logic [5:0]  task_id;
      logic        task_failed;
   } req_word_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [5:0]       handle;
      logic             must_run;
      logic [1:0]       task_state;
      logic [5:0]       readied;
      logic [CNT_W-1:0] outstanding;
      logic             all_done;
      logic [CNT_W-1:0] admitted_total;
      logic [CNT_W-1:0] succeeded_total;
      logic [CNT_W-1:0] failed_total;
      logic [CNT_W-1:0] canceled_total;
   } rsp_word_type;

   // Per-task record kept in the task memory.
   typedef struct packed {
      logic [1:0]        st;
      logic              mark;
      logic              inflight;
      logic [WAIT_W-1:0] waits;
   } task_word_type;

   // Verdicts of the shared task-record unit.
   typedef struct packed {
      logic dep_pending;
      logic dep_bad;
      logic now_ready;
   } word_flags_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SP_INIT, S_SP_RD, S_SP_WR, S_SP_FIN,
      S_DS_RD, S_DS_TK, S_DS_DEC, S_CP_RD, S_CP_DEC,
      S_RS_ROW, S_RS_LATCH, S_RS_RD, S_RS_WR, S_RS_END,
      S_QY_RD, S_QY_GET, S_DONE
   } state_type;

endpackage

/* src/dcts_ram.sv */
module dcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/dcts_word_unit.sv */
module dcts_word_unit (
   input  dcts_pkg::task_word_type  word_i,
   input  logic                     poison_i,
   output dcts_pkg::task_word_type  resolved_o,
   output dcts_pkg::word_flags_type flags_o
);
   import dcts_pkg::*;

   // One record is judged per cycle, both as a dependency at spawn and as a
   // dependent at resolution.
   always_comb begin
      resolved_o      = word_i;
      flags_o.now_ready = 1'b0;
      if (poison_i) begin
         resolved_o.mark = 1'b1;
      end
      if (word_i.waits != '0) begin
         resolved_o.waits = word_i.waits - WAIT_W'(1);
         flags_o.now_ready = (word_i.waits == WAIT_W'(1));
      end
      flags_o.dep_pending = (word_i.st == TS_ADMITTED);
      flags_o.dep_bad     = (word_i.st != TS_ADMITTED) && (word_i.st != TS_SUCCEEDED);
   end

endmodule

/* src/dependency_counting_task_scheduler_unit.sv */
// Channel  Direction  Word            Handshake
// req      in         req_word_type   req_valid / req_stall
// rsp      out        rsp_word_type   rsp_valid / rsp_stall
//
// Cancel, release, unused codes and words turned away at once go straight to
// the result; a query or a completion of a task not in flight reads its record
// first, a dispatch that hands a task out pops the ready stack and a spawn
// walks the dependency bits of lower ids. A completion, and a dispatch that
// cancels in place, walk the dependents row over all MAX_TASKS records, each
// read in one state and written in the next. Reset is synchronous and resets
// only the control state, setting outstanding to one; that walk reads every
// record but writes only those in the row. A finished word waits in the output
// register; the next request is taken meanwhile and its result waits for it.
module dependency_counting_task_scheduler_unit #(
   parameter int MAX_TASKS = dcts_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dcts_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dcts_pkg::rsp_word_type rsp_word
);
   import dcts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TW = $bits(task_word_type);
   localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

   state_type state_ff, state_in;

   // Latched request and scan registers.
   logic [MAX_TASKS-1:0] deps_ff, deps_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        id_ff, id_in;
   task_word_type        word_ff, word_in;
   logic [MAX_TASKS-1:0] row_ff, row_in;
   logic [1:0]           outcome_ff, outcome_in;
   logic                 mark_ff, mark_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;

   // Result being built.
   logic [2:0] status_ff, status_in;
   logic [5:0] handle_ff, handle_in;
   logic       must_run_ff, must_run_in;
   logic [1:0] tstate_ff, tstate_in;
   logic [5:0] readied_ff, readied_in;

   // Scheduler totals.
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] admitted_ff, admitted_in;
   logic [CNT_W-1:0] outstanding_ff, outstanding_in;
   logic [CNT_W-1:0] succ_ff, succ_in;
   logic [CNT_W-1:0] fail_ff, fail_in;
   logic [CNT_W-1:0] canc_ff, canc_in;
   logic             scope_ff, scope_in;
   logic             released_ff, released_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Memory ports.
   logic          task_we, row_we, stk_we;
   logic [IW-1:0] task_waddr, task_raddr, row_waddr, row_raddr, stk_waddr, stk_raddr;
   task_word_type task_wdata, task_rd;
   logic [TW-1:0] task_rd_bits;
   logic [MAX_TASKS-1:0] row_wdata, row_rd;
   logic [5:0]    stk_wdata;
   logic [5:0]    stk_rd;

   task_word_type  unit_word;
   word_flags_type unit_flags;

   logic accept, rsp_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !(rsp_valid_ff && rsp_stall);
   assign task_rd   = task_word_type'(task_rd_bits);

   dcts_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_task_ram (
      .clock(clock), .wr_en(task_we), .wr_addr(task_waddr), .wr_data(TW'(task_wdata)),
      .rd_addr(task_raddr), .rd_data(task_rd_bits)
   );

   dcts_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
      .rd_addr(row_raddr), .rd_data(row_rd)
   );

   dcts_ram #(.WIDTH(6), .DEPTH(MAX_TASKS)) u_stack_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rd)
   );

   dcts_word_unit u_word_unit (
      .word_i(task_rd), .poison_i(outcome_ff != TS_SUCCEEDED),
      .resolved_o(unit_word), .flags_o(unit_flags)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_word.op)
                  OP_SPAWN: begin
                     if (outstanding_ff == '0 || admitted_ff >= CNT_W'(MAX_TASKS)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SP_INIT;
                     end
                  end
                  OP_DISPATCH: state_in = (depth_ff == '0) ? S_DONE : S_DS_RD;
                  OP_COMPLETE: begin
                     state_in = ({1'b0, req_word.task_id} < admitted_ff) ? S_CP_RD : S_DONE;
                  end
                  OP_QUERY: begin
                     state_in = ({1'b0, req_word.task_id} < admitted_ff) ? S_QY_RD : S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SP_INIT:  state_in = (id_ff == '0) ? S_SP_FIN : S_SP_RD;
         S_SP_RD:    state_in = S_SP_WR;
         S_SP_WR:    state_in = ((idx_ff + IW'(1)) == id_ff) ? S_SP_FIN : S_SP_RD;
         S_SP_FIN:   state_in = S_DONE;
         S_DS_RD:    state_in = S_DS_TK;
         S_DS_TK:    state_in = S_DS_DEC;
         S_DS_DEC:   state_in = (task_rd.mark || scope_ff) ? S_RS_ROW : S_DONE;
         S_CP_RD:    state_in = S_CP_DEC;
         S_CP_DEC:   state_in = task_rd.inflight ? S_RS_ROW : S_DONE;
         S_RS_ROW:   state_in = S_RS_LATCH;
         S_RS_LATCH: state_in = S_RS_RD;
         S_RS_RD:    state_in = S_RS_WR;
         S_RS_WR:    state_in = (idx_ff == LAST) ? S_RS_END : S_RS_RD;
         S_RS_END:   state_in = S_DONE;
         S_QY_RD:    state_in = S_QY_GET;
         S_QY_GET:   state_in = S_DONE;
         S_DONE:     state_in = rsp_free ? S_IDLE : S_DONE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      deps_in = deps_ff;
      idx_in = idx_ff; id_in = id_ff; word_in = word_ff; row_in = row_ff;
      outcome_in = outcome_ff; mark_in = mark_ff; wait_in = wait_ff;
      status_in = status_ff; handle_in = handle_ff; must_run_in = must_run_ff;
      tstate_in = tstate_ff; readied_in = readied_ff;
      depth_in = depth_ff; admitted_in = admitted_ff; outstanding_in = outstanding_ff;
      succ_in = succ_ff; fail_in = fail_ff; canc_in = canc_ff;
      scope_in = scope_ff; released_in = released_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;

      task_we = 1'b0; task_waddr = '0; task_wdata = '0; task_raddr = '0;
      row_we = 1'b0; row_waddr = '0; row_wdata = '0; row_raddr = '0;
      stk_we = 1'b0; stk_waddr = depth_ff[IW-1:0]; stk_wdata = '0; stk_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               deps_in = req_word.dep_mask[MAX_TASKS-1:0];
               id_in = req_word.task_id[IW-1:0];
               idx_in = '0;
               status_in = STS_OK; handle_in = req_word.task_id;
               must_run_in = 1'b0; tstate_in = TS_ADMITTED; readied_in = '0;
               unique case (req_word.op)
                  OP_SPAWN: begin
                     handle_in = '0;
                     if (outstanding_ff == '0) begin
                        status_in = STS_DRAINED;
                     end else if (admitted_ff >= CNT_W'(MAX_TASKS)) begin
                        status_in = STS_FULL;
                     end else begin
                        id_in = admitted_ff[IW-1:0];
                        mark_in = scope_ff;
                        wait_in = '0;
                     end
                  end
                  OP_DISPATCH: begin
                     handle_in = '0;
                     if (depth_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else begin
                        depth_in = depth_ff - CNT_W'(1);
                     end
                  end
                  OP_COMPLETE: begin
                     if (!({1'b0, req_word.task_id} < admitted_ff)) begin
                        status_in = STS_BAD_COMPLT;
                     end
                     outcome_in = req_word.task_failed ? TS_FAILED : TS_SUCCEEDED;
                  end
                  OP_CANCEL: scope_in = 1'b1;
                  OP_RELEASE: begin
                     if (released_ff) begin
                        status_in = STS_RELEASED;
                     end else begin
                        released_in = 1'b1;
                        if (outstanding_ff != '0) begin
                           outstanding_in = outstanding_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SP_INIT: begin
            row_we = 1'b1; row_waddr = id_ff; row_wdata = '0;
         end
         S_SP_RD: begin
            task_raddr = idx_ff; row_raddr = idx_ff;
         end
         S_SP_WR: begin
            if (deps_ff[idx_ff]) begin
               if (unit_flags.dep_pending) begin
                  row_we = 1'b1; row_waddr = idx_ff;
                  row_wdata = row_rd | ({{(MAX_TASKS-1){1'b0}}, 1'b1} << id_ff);
                  wait_in = wait_ff + WAIT_W'(1);
               end else if (unit_flags.dep_bad) begin
                  mark_in = 1'b1;
               end
            end
            idx_in = idx_ff + IW'(1);
         end
         S_SP_FIN: begin
            task_we = 1'b1; task_waddr = id_ff;
            task_wdata = '{st: TS_ADMITTED, mark: mark_ff, inflight: 1'b0, waits: wait_ff};
            if (wait_ff == '0 && depth_ff < CNT_W'(MAX_TASKS)) begin
               stk_we = 1'b1; stk_wdata = 6'(id_ff);
               depth_in = depth_ff + CNT_W'(1);
            end
            admitted_in = admitted_ff + CNT_W'(1);
            outstanding_in = outstanding_ff + CNT_W'(1);
            handle_in = 6'(id_ff);
         end
         S_DS_RD: stk_raddr = depth_ff[IW-1:0];
         S_DS_TK: begin
            id_in = stk_rd[IW-1:0];
            task_raddr = stk_rd[IW-1:0];
         end
         S_DS_DEC: begin
            word_in = task_rd;
            handle_in = 6'(id_ff);
            if (task_rd.mark || scope_ff) begin
               outcome_in = TS_CANCELED;
            end else begin
               task_we = 1'b1; task_waddr = id_ff;
               task_wdata = task_rd; task_wdata.inflight = 1'b1;
               must_run_in = 1'b1;
            end
         end
         S_CP_RD: task_raddr = id_ff;
         S_CP_DEC: begin
            word_in = task_rd;
            if (!task_rd.inflight) begin
               status_in = STS_BAD_COMPLT;
            end
         end
         S_RS_ROW: begin
            task_we = 1'b1; task_waddr = id_ff;
            task_wdata = word_ff; task_wdata.st = outcome_ff; task_wdata.inflight = 1'b0;
            unique case (outcome_ff)
               TS_SUCCEEDED: succ_in = succ_ff + CNT_W'(1);
               TS_FAILED:    fail_in = fail_ff + CNT_W'(1);
               default:      canc_in = canc_ff + CNT_W'(1);
            endcase
            row_raddr = id_ff;
            idx_in = '0;
         end
         S_RS_LATCH: row_in = row_rd;
         S_RS_RD: task_raddr = idx_ff;
         S_RS_WR: begin
            if (row_ff[idx_ff]) begin
               task_we = 1'b1; task_waddr = idx_ff; task_wdata = unit_word;
               if (unit_flags.now_ready) begin
                  readied_in = readied_ff + 6'd1;
                  if (depth_ff < CNT_W'(MAX_TASKS)) begin
                     stk_we = 1'b1; stk_wdata = 6'(idx_ff);
                     depth_in = depth_ff + CNT_W'(1);
                  end
               end
            end
            idx_in = idx_ff + IW'(1);
         end
         S_RS_END: begin
            if (outstanding_ff != '0) begin
               outstanding_in = outstanding_ff - CNT_W'(1);
            end
         end
         S_QY_RD: task_raddr = id_ff;
         S_QY_GET: tstate_in = task_rd.st;
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.status = status_ff;
               rsp_word_in.handle = handle_ff;
               rsp_word_in.must_run = must_run_ff;
               rsp_word_in.task_state = tstate_ff;
               rsp_word_in.readied = readied_ff;
               rsp_word_in.outstanding = outstanding_ff;
               rsp_word_in.all_done = (outstanding_ff == '0);
               rsp_word_in.admitted_total = admitted_ff;
               rsp_word_in.succeeded_total = succ_ff;
               rsp_word_in.failed_total = fail_ff;
               rsp_word_in.canceled_total = canc_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         admitted_ff <= '0;
         outstanding_ff <= CNT_W'(1);
         succ_ff <= '0;
         fail_ff <= '0;
         canc_ff <= '0;
         scope_ff <= 1'b0;
         released_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         admitted_ff <= admitted_in;
         outstanding_ff <= outstanding_in;
         succ_ff <= succ_in;
         fail_ff <= fail_in;
         canc_ff <= canc_in;
         scope_ff <= scope_in;
         released_ff <= released_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deps_ff <= deps_in;
      idx_ff <= idx_in; id_ff <= id_in; word_ff <= word_in; row_ff <= row_in;
      outcome_ff <= outcome_in; mark_ff <= mark_in; wait_ff <= wait_in;
      status_ff <= status_in; handle_ff <= handle_in; must_run_ff <= must_run_in;
      tstate_ff <= tstate_in; readied_ff <= readied_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Every stacked task was admitted and is stacked at most once.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= admitted_ff) else $error("ready depth exceeds admitted tasks");

   // Outstanding work is never more than the admitted tasks plus the keepalive.
   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= admitted_ff + CNT_W'(1)) else $error("outstanding too large");

   // Resolved tasks never outnumber admitted ones.
   a_resolved_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, succ_ff} + {1'b0, fail_ff} + {1'b0, canc_ff}) <= {1'b0, admitted_ff})
      else $error("more resolutions than admissions");

   // A taken request word closes the input until its result is produced.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall) else $error("request taken while busy");

endmodule
